// ----- rtl/priority_interrupt_mask_dispatch_unit_defines.svh -----
// Assertion macros shared by the interrupt mask and dispatch unit.
`ifndef PRIORITY_INTERRUPT_MASK_DISPATCH_UNIT_DEFINES_SVH
`define PRIORITY_INTERRUPT_MASK_DISPATCH_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define PIMD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while in reset.
`define PIMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PIMD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PIMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/pimd_pkg.sv -----
// Types, codes and constant tables of the interrupt mask and dispatch unit.
package pimd_pkg;

  // Command codes
  localparam logic [1:0] CMD_DISPATCH = 2'd0;
  localparam logic [1:0] CMD_MASK     = 2'd1;
  localparam logic [1:0] CMD_UNMASK   = 2'd2;
  localparam logic [1:0] CMD_NOP      = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CURRENT_MASK    = 1'b0;
  localparam logic CFG_HANDLER_PRESENT = 1'b1;

  localparam logic [31:0] SOFT_MASK_RESET = 32'hFFFF_FFF0;
  localparam logic [14:0] PI_ENABLE_BASE  = 15'h00F0;
  localparam logic [31:0] SOURCE_BITS     = 32'hFFFF_FFF0;

  // Source groups in mask/cause words (source t at bit 31-t)
  localparam logic [31:0] GRP_MI   = 32'hF800_0000;
  localparam logic [31:0] GRP_DSP  = 32'h0700_0000;
  localparam logic [31:0] GRP_AI   = 32'h0080_0000;
  localparam logic [31:0] GRP_EXI0 = 32'h0070_0000;
  localparam logic [31:0] GRP_EXI1 = 32'h000E_0000;
  localparam logic [31:0] GRP_EXI2 = 32'h0001_8000;
  localparam logic [31:0] GRP_PI   = 32'h0000_7FF0;

  // Processor interface: cause-word bit <-> PI mask register bit
  localparam int PI_MAP_N = 11;
  localparam logic [3:0] PI_MAP_CAUSE [PI_MAP_N] =
    '{4'd14, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd13, 4'd12, 4'd5, 4'd4};
  localparam logic [3:0] PI_MAP_ENABLE [PI_MAP_N] =
    '{4'd11, 4'd3, 4'd2, 4'd1, 4'd0, 4'd8, 4'd12, 4'd9, 4'd10, 4'd13, 4'd14};

  // Fixed priority groups, highest first
  localparam int PRIO_N = 12;
  localparam logic [31:0] PRIO_TABLE [PRIO_N] = '{
    32'h0000_0100, 32'h0000_0040, 32'hF800_0000, 32'h0000_0200,
    32'h0000_0080, 32'h0000_0010, 32'h0000_3000, 32'h0000_0020,
    32'h03FF_8C00, 32'h0400_0000, 32'h0000_4000, 32'hFFFF_FFFF};

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] user_mask;
    logic [16:0] pi_status;
    logic [4:0]  mi_status;
    logic [8:0]  dsp_status;
    logic [7:0]  ai_control;
    logic [11:0] exi0_status;
    logic [11:0] exi1_status;
    logic [11:0] exi2_status;
  } req_t;

  typedef struct packed {
    logic        dispatched;
    logic [4:0]  source_type;
    logic [31:0] old_mask;
    logic [4:0]  mi_enable;
    logic [2:0]  dsp_enable;
    logic        ai_enable;
    logic [2:0]  exi0_enable;
    logic [2:0]  exi1_enable;
    logic [1:0]  exi2_enable;
    logic [14:0] pi_enable;
  } rsp_t;

  // Group enable state
  typedef struct packed {
    logic [4:0]  mi;
    logic [2:0]  dsp;
    logic        ai;
    logic [2:0]  exi0;
    logic [2:0]  exi1;
    logic [1:0]  exi2;
    logic [14:0] pi;
  } grp_t;

  localparam grp_t GRP_RESET = '{mi: 5'd0, dsp: 3'd0, ai: 1'b0, exi0: 3'd0,
                                 exi1: 3'd0, exi2: 2'd0, pi: PI_ENABLE_BASE};

endpackage

// ----- rtl/pimd_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface pimd_req_if;
  import pimd_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pimd_rsp_if;
  import pimd_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/pimd_mask_unit.sv -----
// Mask/unmask update: new software mask and rewritten group enables.
module pimd_mask_unit (
  input  logic [1:0]     command,
  input  logic [31:0]    user_mask,
  input  logic [31:0]    current_mask,
  input  logic [31:0]    soft_mask,
  input  pimd_pkg::grp_t grp,
  output logic [31:0]    soft_mask_next,
  output logic [31:0]    old_mask,
  output pimd_pkg::grp_t grp_next
);
  import pimd_pkg::*;

  logic [31:0] work;
  logic [31:0] eff;
  logic [14:0] pi_new;

  // Changed sources and the new software mask
  always_comb begin
    soft_mask_next = soft_mask;
    work           = '0;
    old_mask       = '0;
    case (command)
      CMD_MASK: begin
        work           = user_mask & ~(soft_mask | current_mask);
        soft_mask_next = soft_mask | user_mask;
        old_mask       = soft_mask;
      end
      CMD_UNMASK: begin
        work           = user_mask & (soft_mask | current_mask);
        soft_mask_next = soft_mask & ~user_mask;
        old_mask       = soft_mask;
      end
      default: ;
    endcase
    work = work & SOURCE_BITS;
  end

  assign eff = soft_mask_next | current_mask;

  // PI mask register image
  always_comb begin
    pi_new = PI_ENABLE_BASE;
    for (int i = 0; i < PI_MAP_N; i++) begin
      if (!eff[PI_MAP_CAUSE[i]]) pi_new[PI_MAP_ENABLE[i]] = 1'b1;
    end
  end

  // Rewrite only groups touched by the change
  always_comb begin
    grp_next = grp;
    if (|(work & GRP_MI)) begin
      for (int i = 0; i < 5; i++) grp_next.mi[i] = ~eff[31-i];
    end
    if (|(work & GRP_DSP)) grp_next.dsp = ~{eff[24], eff[25], eff[26]};
    if (|(work & GRP_AI)) grp_next.ai = ~eff[23];
    if (|(work & GRP_EXI0)) grp_next.exi0 = ~{eff[20], eff[21], eff[22]};
    if (|(work & GRP_EXI1)) grp_next.exi1 = ~{eff[17], eff[18], eff[19]};
    if (|(work & GRP_EXI2)) grp_next.exi2 = ~{eff[15], eff[16]};
    if (|(work & GRP_PI)) grp_next.pi = pi_new;
  end

endmodule

// ----- rtl/pimd_dispatch.sv -----
// Dispatch: cause gathering, masking and fixed-priority source pick.
module pimd_dispatch (
  input  pimd_pkg::req_t req,
  input  logic [31:0]    soft_mask,
  input  logic [31:0]    current_mask,
  input  logic [31:0]    handler_present,
  input  logic [14:0]    pi_enable,
  output logic           dispatched,
  output logic [4:0]     source_type
);
  import pimd_pkg::*;

  logic [15:0] sr;
  logic        pending;
  logic [31:0] cause;
  logic [31:0] masked;
  logic [31:0] sel;
  logic [4:0]  lz;
  logic        found;

  assign sr      = req.pi_status[15:0];
  assign pending = (req.command == CMD_DISPATCH) && (sr != 16'd0) &&
                   ((sr & {1'b0, pi_enable}) != 16'd0);

  // Gather device pending bits into the cause word
  always_comb begin
    cause = '0;
    if (sr[7]) begin
      for (int i = 0; i < 5; i++) cause[31-i] = req.mi_status[i];
    end
    if (sr[6]) begin
      cause[26] = req.dsp_status[3];
      cause[25] = req.dsp_status[5];
      cause[24] = req.dsp_status[7];
    end
    if (sr[5]) cause[23] = req.ai_control[3];
    if (sr[4]) begin
      cause[22] = req.exi0_status[1];
      cause[21] = req.exi0_status[3];
      cause[20] = req.exi0_status[11];
      cause[19] = req.exi1_status[1];
      cause[18] = req.exi1_status[3];
      cause[17] = req.exi1_status[11];
      cause[16] = req.exi2_status[1];
      cause[15] = req.exi2_status[3];
    end
    for (int i = 0; i < PI_MAP_N; i++) begin
      if (sr[PI_MAP_ENABLE[i]]) cause[PI_MAP_CAUSE[i]] = 1'b1;
    end
  end

  assign masked = cause & ~(soft_mask | current_mask);
  assign found  = pending && (masked != 32'd0);

  // First priority group that holds a cause
  always_comb begin
    sel = '0;
    for (int i = PRIO_N - 1; i >= 0; i--) begin
      if (|(masked & PRIO_TABLE[i])) sel = masked & PRIO_TABLE[i];
    end
  end

  // Leading-zero count: highest set bit wins
  always_comb begin
    lz = '0;
    for (int b = 0; b < 32; b++) begin
      if (sel[b]) lz = 5'(31 - b);
    end
  end

  assign source_type = found ? lz : 5'd0;
  assign dispatched  = found && handler_present[lz];

endmodule

// ----- rtl/priority_interrupt_mask_dispatch_unit.sv -----
// Top level of the interrupt mask and priority dispatch unit.
//
// Every request yields one response. A request is captured in an input
// register and its response is then loaded into the output register,
// where it is held valid until taken. The unit takes one request per
// cycle while the response side keeps up; a stalled response holds the
// input register and so stalls the request side.
// Mask, unmask and dispatch all run in a single pass of combinational logic
// between those two registers; the software mask and group enable registers
// are updated when a request moves into the output register, so the next
// request already sees the new state. The configuration registers
// (current_mask, handler_present) should only be written while no request
// is in flight.
`include "priority_interrupt_mask_dispatch_unit_defines.svh"

module priority_interrupt_mask_dispatch_unit (
  input  logic         clk,
  input  logic         rst,
  pimd_req_if.sink     req,
  pimd_rsp_if.source   rsp,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);
  import pimd_pkg::*;

  logic [31:0] current_mask;
  logic [31:0] handler_present;
  logic [31:0] soft_mask;
  logic [31:0] soft_mask_next;
  logic [31:0] old_mask;
  grp_t        grp;
  grp_t        grp_next;
  logic        s1_valid;
  req_t        s1_req;
  logic        rsp_valid;
  rsp_t        rsp_data;
  logic        advance;
  logic        dispatched;
  logic [4:0]  source_type;

  assign advance   = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  pimd_mask_unit u_mask (
    .command        (s1_req.command),
    .user_mask      (s1_req.user_mask),
    .current_mask   (current_mask),
    .soft_mask      (soft_mask),
    .grp            (grp),
    .soft_mask_next (soft_mask_next),
    .old_mask       (old_mask),
    .grp_next       (grp_next)
  );

  pimd_dispatch u_dispatch (
    .req             (s1_req),
    .soft_mask       (soft_mask),
    .current_mask    (current_mask),
    .handler_present (handler_present),
    .pi_enable       (grp.pi),
    .dispatched      (dispatched),
    .source_type     (source_type)
  );

  // Control, state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      rsp_valid       <= 1'b0;
      soft_mask       <= SOFT_MASK_RESET;
      grp             <= GRP_RESET;
      current_mask    <= '0;
      handler_present <= '0;
    end else begin
      if (req.ready) s1_valid <= req.valid;
      if (advance) begin
        rsp_valid <= 1'b1;
        soft_mask <= soft_mask_next;
        grp       <= grp_next;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CURRENT_MASK:    current_mask    <= cfg_data;
          CFG_HANDLER_PRESENT: handler_present <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) s1_req <= req.data;
    if (advance) begin
      rsp_data.dispatched  <= dispatched;
      rsp_data.source_type <= source_type;
      rsp_data.old_mask    <= old_mask;
      rsp_data.mi_enable   <= grp_next.mi;
      rsp_data.dsp_enable  <= grp_next.dsp;
      rsp_data.ai_enable   <= grp_next.ai;
      rsp_data.exi0_enable <= grp_next.exi0;
      rsp_data.exi1_enable <= grp_next.exi1;
      rsp_data.exi2_enable <= grp_next.exi2;
      rsp_data.pi_enable   <= grp_next.pi;
    end
  end

  // Checks
  `PIMD_ASSERT_NEXT(a_state_hold, clk, rst, !advance, $stable({soft_mask, grp}), "state moved")
  `PIMD_ASSERT_IMPL(a_pi_base, clk, rst, 1'b1, grp.pi[7:4] == 4'hF, "PI base bits lost")
  `PIMD_ASSERT_IMPL(a_no_overrun, clk, rst, s1_valid && !advance, !req.ready, "input overrun")
  `PIMD_ASSERT_IMPL(a_disp_no_old, clk, rst, rsp_valid && rsp_data.dispatched, rsp_data.old_mask == '0, "old mask")

endmodule
